// ----- src/bcd_pkg.sv -----
`default_nettype none

package bcd_pkg;

  // width of the pin sample field; buttons above it read as released
  localparam int IN_BITS = 4;
  // reports kept per tick
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W = $clog2(MAX_RESULTS);

  // hold steps are kept as quotient and remainder by five
  localparam logic [2:0] GROUP_LAST = 3'd4;
  localparam logic [13:0] Q_MAX = 14'd13107;  // 65535 / 5, remainder zero

  localparam logic PRESSED_LEVEL_RST = 1'b0;

  typedef enum logic [2:0] {
    REG_DEBOUNCE       = 3'd0,
    REG_HOLD_PERIOD    = 3'd1,
    REG_RELEASE_WINDOW = 3'd2,
    REG_PRESS_LIMIT    = 3'd3,
    REG_HOLD_LIMIT     = 3'd4,
    REG_PRESSED_LEVEL  = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_HOLD  = 2'd0,
    KIND_CLICK = 2'd1,
    KIND_CODE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  debounce_samples;
    logic [15:0] hold_period_ticks;
    logic [15:0] release_window_ticks;
    logic [7:0]  press_limit;
    logic [7:0]  hold_limit;
    logic        pressed_level;
  } cfg_t;

  typedef struct packed {
    logic press_start;    // accepted press of a button not yet pressed
    logic release_event;  // accepted release
    logic pressed;        // pressed after debounce
  } lane_status_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] code;
    logic       unk;
  } report_t;

  function automatic logic [7:0] hold_code(input logic [13:0] q, input logic [7:0] base);
    logic [14:0] sum;
    logic [7:0]  res;
    sum = {1'b0, q} + {7'd0, base};
    res = (sum > 15'd255) ? 8'hFF : sum[7:0];
    return res;
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    logic [15:0] res;
    res = (v == 16'd0) ? 16'd1 : v;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/bcd_lane.sv -----
`default_nettype none

module bcd_lane (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             sample,
  input  wire bcd_pkg::cfg_t    cfg,
  input  wire logic             hold_fire,
  input  wire logic             release_fire,
  output bcd_pkg::lane_status_t status,
  output bcd_pkg::report_t      hold_rep,
  output bcd_pkg::report_t      rel_rep
);
  import bcd_pkg::*;

  logic        prev, stable, pressed, released, holding;
  logic [7:0]  run, click;
  logic [13:0] q;
  logic [2:0]  r;

  logic        prev_next, stable_next, pressed_next, released_next, holding_next;
  logic [7:0]  run_next, click_next;
  logic [13:0] q_next;
  logic [2:0]  r_next;

  logic [7:0]  need;
  logic        take_lvl, press_ev, release_ev;
  logic        pressed_mid;

  always_comb begin
    need = (cfg.debounce_samples == 8'd0) ? 8'd1 : cfg.debounce_samples;

    // debounce
    if (sample == prev) begin
      run_next = (run == 8'hFF) ? run : run + 8'd1;
    end else begin
      run_next = 8'd1;
    end
    prev_next = sample;
    take_lvl = (run_next >= need) && (sample != stable);
    press_ev = take_lvl && (sample == cfg.pressed_level);
    release_ev = take_lvl && (sample != cfg.pressed_level);

    stable_next = take_lvl ? sample : stable;
    pressed_next = pressed;
    released_next = released;
    holding_next = holding;
    click_next = click;
    q_next = q;
    r_next = r;
    if (press_ev) begin
      click_next = (click == 8'hFF) ? click : click + 8'd1;
      holding_next = 1'b0;
      q_next = '0;
      r_next = '0;
      pressed_next = 1'b1;
      released_next = 1'b0;
    end else if (release_ev) begin
      released_next = 1'b1;
      pressed_next = 1'b0;
    end
    pressed_mid = pressed_next;

    status.press_start = press_ev && !pressed;
    status.release_event = release_ev;
    status.pressed = pressed_mid;

    // hold step
    hold_rep = '0;
    hold_rep.kind = KIND_HOLD;
    if (hold_fire && pressed_mid) begin
      if (!(q_next == Q_MAX && r_next == 3'd0)) begin
        if (r_next == GROUP_LAST) begin
          r_next = 3'd0;
          q_next = q_next + 14'd1;
        end else begin
          r_next = r_next + 3'd1;
        end
      end
      if (q_next != 14'd0) begin
        holding_next = 1'b1;
        click_next = 8'd0;
      end
      if (r_next == 3'd0) begin
        hold_rep.valid = 1'b1;
        hold_rep.code = hold_code(q_next, cfg.press_limit);
      end
    end

    // release window closed: report and clear
    rel_rep = '0;
    rel_rep.kind = KIND_CLICK;
    if (release_fire && released_next) begin
      rel_rep.valid = 1'b1;
      if (!holding_next) begin
        rel_rep.kind = KIND_CLICK;
        rel_rep.code = click_next;
        rel_rep.unk = (click_next >= cfg.press_limit);
      end else begin
        rel_rep.kind = KIND_CODE;
        rel_rep.code = hold_code(q_next, cfg.press_limit);
        rel_rep.unk = (rel_rep.code >= cfg.hold_limit);
      end
      stable_next = ~cfg.pressed_level;
      pressed_next = 1'b0;
      released_next = 1'b0;
      holding_next = 1'b0;
      click_next = 8'd0;
      q_next = '0;
      r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= ~PRESSED_LEVEL_RST;
      stable <= ~PRESSED_LEVEL_RST;
      run <= '0;
      pressed <= 1'b0;
      released <= 1'b0;
      holding <= 1'b0;
      click <= '0;
      q <= '0;
      r <= '0;
    end else if (en) begin
      prev <= prev_next;
      stable <= stable_next;
      run <= run_next;
      pressed <= pressed_next;
      released <= released_next;
      holding <= holding_next;
      click <= click_next;
      q <= q_next;
      r <= r_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/bcd_timers.sv -----
`default_nettype none

module bcd_timers (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire bcd_pkg::cfg_t cfg,
  input  wire logic          press_start_any,
  input  wire logic          release_any,
  input  wire logic          pressed_any,
  output logic               hold_fire,
  output logic               release_fire
);
  import bcd_pkg::*;

  logic        hold_armed, release_armed;
  logic [15:0] hold_timer, release_timer;
  logic        hold_armed_next, release_armed_next;
  logic [15:0] hold_timer_next, release_timer_next;
  logic        h_armed_mid, r_armed_mid;
  logic [15:0] h_timer_mid, r_timer_mid;

  always_comb begin
    // a fresh press forces a hold step in the same tick
    h_armed_mid = hold_armed || press_start_any;
    h_timer_mid = press_start_any ? 16'd0 : hold_timer;
    hold_fire = h_armed_mid && (h_timer_mid <= 16'd1);
    hold_armed_next = h_armed_mid;
    hold_timer_next = h_timer_mid;
    if (hold_fire) begin
      hold_armed_next = pressed_any;
      hold_timer_next = pressed_any ? at_least_one(cfg.hold_period_ticks) : 16'd0;
    end else if (h_armed_mid) begin
      hold_timer_next = h_timer_mid - 16'd1;
    end

    r_armed_mid = release_armed || release_any;
    r_timer_mid = release_any ? at_least_one(cfg.release_window_ticks) : release_timer;
    release_fire = r_armed_mid && (r_timer_mid <= 16'd1);
    release_armed_next = r_armed_mid;
    release_timer_next = r_timer_mid;
    if (release_fire) begin
      release_armed_next = 1'b0;
      release_timer_next = 16'd0;
    end else if (r_armed_mid) begin
      release_timer_next = r_timer_mid - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_armed <= 1'b0;
      hold_timer <= '0;
      release_armed <= 1'b0;
      release_timer <= '0;
    end else if (en) begin
      hold_armed <= hold_armed_next;
      hold_timer <= hold_timer_next;
      release_armed <= release_armed_next;
      release_timer <= release_timer_next;
    end
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !hold_armed |-> hold_timer == 16'd0)
    else $error("hold timer running while disarmed");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    !release_armed |-> release_timer == 16'd0)
    else $error("release timer running while disarmed");

endmodule

`default_nettype wire

// ----- src/bcd_queue.sv -----
`default_nettype none

module bcd_queue #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bcd_pkg::report_t hold_reps [NUM_BUTTONS],
  input  wire bcd_pkg::report_t rel_reps [NUM_BUTTONS],
  output logic                  empty,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            button_index,
  output logic [1:0]            report_kind,
  output logic [7:0]            event_code,
  output logic                  is_unknown,
  output logic                  last_report
);
  import bcd_pkg::*;

  // hold reports by button first, then release reports by button
  localparam int ENTRIES = 2 * NUM_BUTTONS;
  localparam int IDX_W = $clog2(ENTRIES);

  logic [ENTRIES-1:0] pend;
  kind_t              kind_q [ENTRIES];
  logic [7:0]         code_q [ENTRIES];
  logic               unk_q [ENTRIES];
  logic [CNT_W-1:0]   cnt;

  logic               found, pick_last, drain;
  logic [IDX_W-1:0]   pick;
  logic [1:0]         pick_btn;
  logic [ENTRIES-1:0] sel;

  always_comb begin
    found = 1'b0;
    pick = '0;
    pick_btn = '0;
    sel = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (pend[j] && !found) begin
        found = 1'b1;
        pick = IDX_W'(j);
        pick_btn = 2'(j % NUM_BUTTONS);
        sel[j] = 1'b1;
      end
    end
    pick_last = ((pend & ~sel) == '0) || (cnt == CNT_W'(MAX_RESULTS - 1));
    drain = found && (!out_valid || out_ready);
  end

  assign empty = (pend == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt <= '0;
    end else if (load) begin
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        pend[j] <= hold_reps[j].valid;
        pend[NUM_BUTTONS + j] <= rel_reps[j].valid;
      end
      cnt <= '0;
    end else if (drain) begin
      // past the per-tick limit the rest is dropped
      if (cnt == CNT_W'(MAX_RESULTS - 1)) begin
        pend <= '0;
      end else begin
        pend <= pend & ~sel;
      end
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        kind_q[j] <= hold_reps[j].kind;
        code_q[j] <= hold_reps[j].code;
        unk_q[j] <= hold_reps[j].unk;
        kind_q[NUM_BUTTONS + j] <= rel_reps[j].kind;
        code_q[NUM_BUTTONS + j] <= rel_reps[j].code;
        unk_q[NUM_BUTTONS + j] <= rel_reps[j].unk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      button_index <= pick_btn;
      report_kind <= kind_q[pick];
      event_code <= code_q[pick];
      is_unknown <= unk_q[pick];
      last_report <= pick_last;
    end
  end

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    drain && pick_last |=> pend == '0)
    else $error("reports left after last of tick");

  a_not_last_keeps: assert property (@(posedge clk) disable iff (rst)
    drain && !pick_last |=> pend != '0)
    else $error("queue ran dry without a last report");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> cnt == '0 && out_valid == $past(out_valid && !out_ready))
    else $error("load disturbed count or output");

endmodule

`default_nettype wire

// ----- src/button_click_and_hold_detector_unit.sv -----
// The first report of a tick goes through the queue registers and then the output register.
// A tick with no reports does not block input; one with R reports (R <= 8) blocks
// input while the report queue drains one per cycle, unless the output stalls.
// The output register lets the next item in while the last report waits to be taken.
// Reset (synchronous, rst high): registers to defaults, all buttons released and cleared,
// both timers disarmed, queue and output empty.
`default_nettype none

module button_click_and_hold_detector_unit #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  pin_levels,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       button_index,
  output logic [1:0]       report_kind,
  output logic [7:0]       event_code,
  output logic             is_unknown,
  output logic             last_report,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import bcd_pkg::*;

  cfg_t         cfg;
  logic         in_accept, empty;
  logic         hold_fire, release_fire;
  logic         press_start_any, release_any, pressed_any;
  lane_status_t status [NUM_BUTTONS];
  report_t      hold_reps [NUM_BUTTONS];
  report_t      rel_reps [NUM_BUTTONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_samples <= 8'd5;
      cfg.hold_period_ticks <= 16'd200;
      cfg.release_window_ticks <= 16'd500;
      cfg.press_limit <= 8'd6;
      cfg.hold_limit <= 8'd17;
      cfg.pressed_level <= PRESSED_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:       cfg.debounce_samples <= cfg_data[7:0];
        REG_HOLD_PERIOD:    cfg.hold_period_ticks <= cfg_data;
        REG_RELEASE_WINDOW: cfg.release_window_ticks <= cfg_data;
        REG_PRESS_LIMIT:    cfg.press_limit <= cfg_data[7:0];
        REG_HOLD_LIMIT:     cfg.hold_limit <= cfg_data[7:0];
        REG_PRESSED_LEVEL:  cfg.pressed_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = empty;
  assign in_accept = in_valid && in_ready;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic sample;
    if (i < IN_BITS) begin : g_pin
      assign sample = pin_levels[i];
    end else begin : g_nopin
      assign sample = ~cfg.pressed_level;
    end

    bcd_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .en           (in_accept),
      .sample       (sample),
      .cfg          (cfg),
      .hold_fire    (hold_fire),
      .release_fire (release_fire),
      .status       (status[i]),
      .hold_rep     (hold_reps[i]),
      .rel_rep      (rel_reps[i])
    );
  end

  always_comb begin
    press_start_any = 1'b0;
    release_any = 1'b0;
    pressed_any = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_start_any = press_start_any | status[i].press_start;
      release_any = release_any | status[i].release_event;
      pressed_any = pressed_any | status[i].pressed;
    end
  end

  bcd_timers u_timers (
    .clk             (clk),
    .rst             (rst),
    .en              (in_accept),
    .cfg             (cfg),
    .press_start_any (press_start_any),
    .release_any     (release_any),
    .pressed_any     (pressed_any),
    .hold_fire       (hold_fire),
    .release_fire    (release_fire)
  );

  bcd_queue #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .load         (in_accept),
    .hold_reps    (hold_reps),
    .rel_reps     (rel_reps),
    .empty        (empty),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .report_kind  (report_kind),
    .event_code   (event_code),
    .is_unknown   (is_unknown),
    .last_report  (last_report)
  );

endmodule

`default_nettype wire

// ----- bench/click_report_checker.sv -----
module click_report_checker #(
  parameter int NUM_BUTTONS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [3:0]  pin_levels,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  button_index,
  input  wire logic [1:0]  report_kind,
  input  wire logic [7:0]  event_code,
  input  wire logic        is_unknown,
  input  wire logic        last_report,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               error_count,
  output int               outstanding,
  output int               reports_seen
);
  import bcd_pkg::*;

  localparam int STEPS_PER_REPORT = 5;

  typedef struct packed {
    logic [1:0] button;
    kind_t      kind;
    logic [7:0] code;
    logic       unknown;
    logic       last;
  } button_report_t;

  // register copies
  logic [7:0]  db_samples;
  logic [15:0] hold_period;
  logic [15:0] release_window;
  logic [7:0]  press_lim;
  logic [7:0]  hold_lim;
  logic        press_lvl;

  // per-button state
  logic        stable_lvl [NUM_BUTTONS];
  logic        prev_lvl   [NUM_BUTTONS];
  logic [7:0]  run_len    [NUM_BUTTONS];
  logic        is_pressed [NUM_BUTTONS];
  logic        is_released[NUM_BUTTONS];
  logic        is_holding [NUM_BUTTONS];
  logic [7:0]  clicks     [NUM_BUTTONS];
  logic [15:0] steps      [NUM_BUTTONS];

  logic hold_on;
  int   hold_cnt;
  logic window_on;
  int   window_cnt;

  button_report_t expected_reports[$];
  button_report_t want;
  int err_total;
  int seen_total;

  function automatic int floor_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int hold_level(input int i);
    return int'(steps[i]) / STEPS_PER_REPORT + int'(press_lim);
  endfunction

  function automatic button_report_t make_report(input int idx, input kind_t kind,
                                                 input int value, input logic unk);
    button_report_t r;
    r.button  = idx[1:0];
    r.kind    = kind;
    r.code    = (value > 255) ? 8'hFF : value[7:0];
    r.unknown = unk;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic clear_button(input int i);
    stable_lvl[i]  = ~press_lvl;
    is_pressed[i]  = 1'b0;
    is_released[i] = 1'b0;
    is_holding[i]  = 1'b0;
    clicks[i]      = '0;
    steps[i]       = '0;
  endtask

  task automatic reset_model();
    db_samples     = 8'd5;
    hold_period    = 16'd200;
    release_window = 16'd500;
    press_lim      = 8'd6;
    hold_lim       = 8'd17;
    press_lvl      = PRESSED_LEVEL_RST;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      clear_button(i);
      prev_lvl[i] = ~press_lvl;
      run_len[i]  = '0;
    end
    hold_on    = 1'b0;
    hold_cnt   = 0;
    window_on  = 1'b0;
    window_cnt = 0;
    expected_reports.delete();
  endtask

  // one sample tick: debounce, then hold timer, then release window
  task automatic sample_tick(input logic [3:0] pins);
    int             need;
    int             first;
    int             code;
    logic           s;
    logic           any;
    button_report_t r;
    need  = floor_one(int'(db_samples));
    first = expected_reports.size();

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      s = (i < IN_BITS) ? pins[i] : ~press_lvl;
      if (s == prev_lvl[i]) begin
        if (run_len[i] != 8'hFF) run_len[i]++;
      end else begin
        run_len[i] = 8'd1;
      end
      prev_lvl[i] = s;
      if (int'(run_len[i]) >= need && s != stable_lvl[i]) begin
        stable_lvl[i] = s;
        if (s == press_lvl) begin
          if (clicks[i] != 8'hFF) clicks[i]++;
          // fresh press forces a hold step this tick
          if (!is_pressed[i]) begin
            hold_on  = 1'b1;
            hold_cnt = 0;
          end
          is_holding[i]  = 1'b0;
          steps[i]       = '0;
          is_pressed[i]  = 1'b1;
          is_released[i] = 1'b0;
        end else begin
          is_released[i] = 1'b1;
          is_pressed[i]  = 1'b0;
          window_on      = 1'b1;
          window_cnt     = floor_one(int'(release_window));
        end
      end
    end

    if (hold_on) begin
      if (hold_cnt <= 1) begin
        any = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (is_pressed[i]) begin
            any = 1'b1;
            if (steps[i] != 16'hFFFF) steps[i]++;
            if (int'(steps[i]) >= STEPS_PER_REPORT) begin
              is_holding[i] = 1'b1;
              clicks[i]     = '0;
            end
            if (int'(steps[i]) % STEPS_PER_REPORT == 0)
              expected_reports.push_back(make_report(i, KIND_HOLD, hold_level(i), 1'b0));
          end
        end
        hold_on  = any;
        hold_cnt = any ? floor_one(int'(hold_period)) : 0;
      end else begin
        hold_cnt--;
      end
    end

    if (window_on) begin
      if (window_cnt <= 1) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (is_released[i]) begin
            if (!is_holding[i]) begin
              expected_reports.push_back(make_report(i, KIND_CLICK, int'(clicks[i]),
                                                     clicks[i] >= press_lim));
            end else begin
              code = hold_level(i);
              expected_reports.push_back(make_report(i, KIND_CODE, code,
                                                     code >= int'(hold_lim)));
            end
            clear_button(i);
          end
        end
        window_on  = 1'b0;
        window_cnt = 0;
      end else begin
        window_cnt--;
      end
    end

    // reports past the per-tick limit are dropped
    while (expected_reports.size() > first + MAX_RESULTS)
      void'(expected_reports.pop_back());

    if (expected_reports.size() > first) begin
      r = expected_reports[expected_reports.size() - 1];
      r.last = 1'b1;
      expected_reports[expected_reports.size() - 1] = r;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      err_total  = 0;
      seen_total = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DEBOUNCE:       db_samples     = cfg_data[7:0];
          REG_HOLD_PERIOD:    hold_period    = cfg_data;
          REG_RELEASE_WINDOW: release_window = cfg_data;
          REG_PRESS_LIMIT:    press_lim      = cfg_data[7:0];
          REG_HOLD_LIMIT:     hold_lim       = cfg_data[7:0];
          REG_PRESSED_LEVEL:  press_lvl      = cfg_data[0];
          default: ;
        endcase
      end
      // output first: a result on this edge belongs to an earlier item
      if (out_valid && out_ready) begin
        seen_total++;
        if (expected_reports.size() == 0) begin
          $error("report with nothing expected: button %0d kind %0d code %0d",
                 button_index, report_kind, event_code);
          err_total++;
        end else begin
          want = expected_reports.pop_front();
          check_field("button_index", 8'(want.button), 8'(button_index));
          check_field("report_kind", 8'(want.kind), 8'(report_kind));
          check_field("event_code", want.code, event_code);
          check_field("is_unknown", 8'(want.unknown), 8'(is_unknown));
          check_field("last_report", 8'(want.last), 8'(last_report));
        end
      end
      if (in_valid && in_ready) sample_tick(pin_levels);
    end
    error_count  <= err_total;
    outstanding  <= expected_reports.size();
    reports_seen <= seen_total;
  end

endmodule

// ----- bench/button_click_and_hold_detector_unit_tb.sv -----
module button_click_and_hold_detector_unit_tb;
  import bcd_pkg::*;

  localparam int LONG_STALL    = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  pin_levels;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  button_index;
  logic [1:0]  report_kind;
  logic [7:0]  event_code;
  logic        is_unknown;
  logic        last_report;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int error_count;
  int outstanding;
  int reports_seen;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stalls_served = 0;
  int ticks_sent = 0;

  // effective settings, zero acting as one
  int   db_eff;
  int   hp_eff;
  int   rw_eff;
  logic lvl_now;

  // all pressed/held/released, a double click on button 0, a single click on button 3
  logic [3:0] directed_pins [25] = '{
    4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
    4'hE, 4'hF, 4'hE, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
    4'h7, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF
  };

  always #5 clk = ~clk;

  button_click_and_hold_detector_unit u_dut (.*);

  click_report_checker u_check (.*);

  // receiver: random backpressure, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != stall_requests) begin
        stalls_served = stalls_served + 1;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic [3:0] pins);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pin_levels <= pins;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // buttons in mask pressed, others released; occasional contact bounce
  task automatic press_for(input logic [3:0] mask, input int n);
    logic [3:0] pins;
    repeat (n) begin
      pins = lvl_now ? mask : ~mask;
      if ($urandom_range(0, 19) == 0) pins ^= 4'($urandom);
      send_tick(pins);
    end
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < DRAIN_LIMIT && outstanding != 0; k++) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] db, input logic [15:0] hp,
                                input logic [15:0] rw, input logic [7:0] pl,
                                input logic [7:0] hl, input logic lvl);
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_DEBOUNCE, 16'(db));
    write_reg(REG_HOLD_PERIOD, hp);
    write_reg(REG_RELEASE_WINDOW, rw);
    write_reg(REG_PRESS_LIMIT, 16'(pl));
    write_reg(REG_HOLD_LIMIT, 16'(hl));
    write_reg(REG_PRESSED_LEVEL, 16'(lvl));
    cfg_write <= 1'b0;
    db_eff  = (db == 0) ? 1 : int'(db);
    hp_eff  = (hp == 0) ? 1 : int'(hp);
    rw_eff  = (rw == 0) ? 1 : int'(rw);
    lvl_now = lvl;
  endtask

  // mostly well-formed click bursts and holds, some raw noise and short presses
  task automatic random_gestures(input int goal);
    int         items0;
    int         reports0;
    logic [3:0] mask;
    int         choice;
    items0   = ticks_sent;
    reports0 = reports_seen;
    while ((ticks_sent - items0 < goal || reports_seen - reports0 < 3) &&
           ticks_sent - items0 < goal + 40) begin
      mask   = 4'($urandom_range(1, 15));
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        repeat ($urandom_range(2, 6)) send_tick(4'($urandom));
      end else if (choice < 6) begin
        repeat ($urandom_range(1, 4)) begin
          press_for(mask, db_eff + $urandom_range(0, 2));
          press_for(4'h0, db_eff + $urandom_range(0, 1));
        end
      end else if (choice < 9) begin
        press_for(mask, db_eff + $urandom_range(4, 10) * hp_eff);
      end else begin
        press_for(mask, $urandom_range(1, db_eff));
      end
      // mostly let the window close, sometimes merge into the next gesture
      if ($urandom_range(0, 3) != 0) press_for(4'h0, rw_eff + db_eff + 1);
      else press_for(4'h0, $urandom_range(1, rw_eff));
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    pin_levels = 4'h0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 68;
    apply_settings(8'd1, 16'd1, 16'd4, 8'd2, 8'd7, 1'b0);
    foreach (directed_pins[i]) send_tick(directed_pins[i]);

    apply_settings(8'd1, 16'd1, 16'd3, 8'd3, 8'd8, 1'b0);
    random_gestures(20);
    // hold everything while the receiver is stalled: reports back up into the input
    stall_requests <= stall_requests + 1;
    press_for(4'hF, 16);
    press_for(4'h0, 4);

    send_idle_pct = 68;
    recv_idle_pct = 14;
    apply_settings(8'd3, 16'd2, 16'd5, 8'd1, 8'd1, 1'b1);
    random_gestures(12);
    wait_empty();
    random_gestures(12);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(8'd0, 16'd0, 16'd0, 8'd255, 8'd255, 1'b0);
    random_gestures(15);

    wait_empty();
    repeat (20) @(posedge clk);
    if (outstanding != 0) $error("%0d expected reports never arrived", outstanding);
    if (error_count == 0 && outstanding == 0) begin
      $display("button_click_and_hold_detector_unit_tb: done, clean");
    end else begin
      $display("button_click_and_hold_detector_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("button_click_and_hold_detector_unit_tb: done, errors");
    $finish;
  end

endmodule
